/* rtl/core/bbd_pkg.sv */
// Package for the bounded byte deque: widths, status codes, reset constants
// and the control struct between the top level and the entry store.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bbd_pkg;

    localparam int DEPTH_DEFAULT = 128;
    localparam int BYTE_W        = 8;
    localparam int CNT_W         = 8;
    localparam int STATUS_W      = 2;

    localparam logic [CNT_W-1:0]    LIMIT_RESET = 8'd100;
    localparam logic [BYTE_W-1:0]   EMPTY_FILL  = 8'h20;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    typedef struct packed {
        logic wr;
        logic rd;
    } mem_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/bbd_store.sv */
// Entry store of the bounded byte deque: one synchronous memory with a
// single address, one write or one read per cycle and registered read data.
// Depends on bbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbd_store #(
    parameter int DEPTH = bbd_pkg::DEPTH_DEFAULT,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  wire                          clk,
    input  bbd_pkg::mem_ctl_t            ctl,
    input  wire  [IDX_W-1:0]             addr,
    input  wire  [bbd_pkg::BYTE_W-1:0]   wdata,
    output logic [bbd_pkg::BYTE_W-1:0]   rdata
);

    logic [bbd_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [bbd_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/bounded_byte_deque.sv */
// Top level of the bounded byte deque: ring pointers, count, limit register,
// result stage and output register around the entry store.
// Depends on bbd_pkg and bbd_store.
//
//   channel   direction   handshake               word
//   in        sink        in_valid / in_stall     req_type, direction, push_byte
//   out       source      out_valid / out_stall   pop_byte, status, occupancy
//   cfg       sink        cfg_valid / cfg_ready   capacity_limit
//
// One word is accepted per cycle while in_stall is low; its result is registered
// in the result stage, alongside the memory access, and then in the output register.
// The memory port handles one access per cycle, which sets the rate.
// Reset clears the pointers and the count and loads the limit with 100.
// A stalled result holds the output; the input stalls only once the
// result stage behind it is also full.
`timescale 1ns / 1ps
`default_nettype none

module bounded_byte_deque #(
    parameter int DEPTH = bbd_pkg::DEPTH_DEFAULT
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire                            req_type,
    input  wire                            direction,
    input  wire  [bbd_pkg::BYTE_W-1:0]     push_byte,
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic [bbd_pkg::BYTE_W-1:0]     pop_byte,
    output logic [bbd_pkg::STATUS_W-1:0]   status,
    output logic [bbd_pkg::CNT_W-1:0]      occupancy,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire  [bbd_pkg::CNT_W-1:0]      capacity_limit
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);
    localparam logic [bbd_pkg::CNT_W-1:0] CNT_ONE = bbd_pkg::CNT_W'(1);

    logic [IDX_W-1:0]              head_reg, head_next;
    logic [IDX_W-1:0]              tail_reg, tail_next;
    logic [bbd_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [bbd_pkg::CNT_W-1:0]     limit_reg;

    logic                          s1_valid_reg;
    logic                          s1_read_reg, s1_read_next;
    logic [bbd_pkg::STATUS_W-1:0]  s1_status_reg, s1_status_next;
    logic [bbd_pkg::BYTE_W-1:0]    s1_byte_reg, s1_byte_next;
    logic [bbd_pkg::CNT_W-1:0]     s1_occ_reg;

    logic                          out_valid_reg;
    logic [bbd_pkg::BYTE_W-1:0]    pop_byte_reg;
    logic [bbd_pkg::STATUS_W-1:0]  status_reg;
    logic [bbd_pkg::CNT_W-1:0]     occupancy_reg;

    logic                          in_fire, s1_adv, full, empty;
    logic [IDX_W-1:0]              head_prev, head_inc, tail_prev, tail_inc;
    logic [IDX_W-1:0]              mem_addr;
    bbd_pkg::mem_ctl_t             mem_ctl;
    logic [bbd_pkg::BYTE_W-1:0]    mem_rdata;

    assign s1_adv    = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign full  = (count_reg >= limit_reg) || (32'(count_reg) >= DEPTH);
    assign empty = (count_reg == '0);

    assign head_prev = (head_reg == '0) ? LAST_IDX : head_reg - IDX_ONE;
    assign head_inc  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_ONE;
    assign tail_prev = (tail_reg == '0) ? LAST_IDX : tail_reg - IDX_ONE;
    assign tail_inc  = (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_ONE;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        mem_ctl        = '0;
        mem_addr       = head_reg;
        s1_read_next   = 1'b0;
        s1_status_next = bbd_pkg::ST_OK;
        s1_byte_next   = '0;
        if (in_fire)
        begin
            if (req_type == bbd_pkg::REQ_PUSH)
            begin
                if (full)
                begin
                    s1_status_next = bbd_pkg::ST_FULL;
                end
                else
                begin
                    mem_ctl.wr = 1'b1;
                    count_next = count_reg + CNT_ONE;
                    if (!direction)
                    begin
                        mem_addr  = head_prev;
                        head_next = head_prev;
                    end
                    else
                    begin
                        mem_addr  = tail_reg;
                        tail_next = tail_inc;
                    end
                end
            end
            else
            begin
                if (empty)
                begin
                    s1_status_next = bbd_pkg::ST_EMPTY;
                    s1_byte_next   = bbd_pkg::EMPTY_FILL;
                end
                else
                begin
                    mem_ctl.rd   = 1'b1;
                    s1_read_next = 1'b1;
                    count_next   = count_reg - CNT_ONE;
                    if (!direction)
                    begin
                        mem_addr  = tail_prev;
                        tail_next = tail_prev;
                    end
                    else
                    begin
                        mem_addr  = head_reg;
                        head_next = head_inc;
                    end
                end
            end
        end
    end

    bbd_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (push_byte),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            limit_reg     <= bbd_pkg::LIMIT_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= capacity_limit;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_read_reg   <= s1_read_next;
            s1_status_reg <= s1_status_next;
            s1_byte_reg   <= s1_byte_next;
            s1_occ_reg    <= count_next;
        end
        if (s1_adv && s1_valid_reg)
        begin
            pop_byte_reg  <= s1_read_reg ? mem_rdata : s1_byte_reg;
            status_reg    <= s1_status_reg;
            occupancy_reg <= s1_occ_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pop_byte  = pop_byte_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

endmodule

`default_nettype wire

/* rtl/core/bbd_checker.sv */
// Port-level checker for the bounded byte deque and its bind to the top level.
// Depends on bbd_pkg and bounded_byte_deque.
`timescale 1ns / 1ps
`default_nettype none

module bbd_assertions #(
    parameter int DEPTH = bbd_pkg::DEPTH_DEFAULT
) (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            in_valid,
    input wire                            in_stall,
    input wire                            out_valid,
    input wire                            out_stall,
    input wire [bbd_pkg::BYTE_W-1:0]      pop_byte,
    input wire [bbd_pkg::STATUS_W-1:0]    status,
    input wire [bbd_pkg::CNT_W-1:0]       occupancy
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pop_byte)
            && $stable(status) && $stable(occupancy))
        else $error("Stalled result word changed.");

    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == bbd_pkg::ST_EMPTY
            |-> pop_byte == bbd_pkg::EMPTY_FILL && occupancy == '0)
        else $error("Empty pop word is malformed.");

    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == bbd_pkg::ST_FULL |-> pop_byte == '0)
        else $error("Refused push carries a data byte.");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(occupancy) <= DEPTH)
        else $error("Occupancy exceeds the storage depth.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |-> out_valid && out_stall)
        else $error("Input stalled while the output was free.");

endmodule

bind bounded_byte_deque bbd_assertions #(
    .DEPTH (DEPTH)
) u_bbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pop_byte  (pop_byte),
    .status    (status),
    .occupancy (occupancy)
);

`default_nettype wire
